@@ sv/tbs_pkg.sv @@
// tbs_pkg: shared types and constants for the transfer block splitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_SHARD_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHARD_W = 3'd4;

  localparam logic [5:0] LAST_PIECE_NUM = 6'd63;

  typedef struct packed {
    logic [10:0] channels;
    logic [12:0] in_shard_w;
    logic [3:0]  elem_size;
    logic [12:0] blk_width;
    logic [12:0] out_shard_w;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  from_core;
    logic [5:0]  dst_core;
    logic [7:0]  noc_x;
    logic [7:0]  noc_y;
    logic [30:0] src_base;
    logic [24:0] row_bs;
    logic [13:0] start;
    logic [13:0] lim;
    logic [13:0] bstart;
    logic [5:0]  blk;
  } job_t;

  typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_ROW, FR_PUSH} front_state_t;
  typedef enum logic [1:0] {BK_IDLE, BK_CALC, BK_SEND} back_state_t;

endpackage
`default_nettype wire

@@ sv/transfer_block_splitter.sv @@
// transfer_block_splitter: top level; config registers, front, job queue, back.
// Depends on tbs_pkg, tbs_front, tbs_queue, tbs_back.
//
//   channel | direction | handshake          | beat
//   in      | in        | in_valid/in_stall  | one transfer descriptor
//   out     | out       | out_valid/out_stall| one piece
//   cfg     | in        | cfg_valid/cfg_ready| one register write
//
// Front takes no new descriptor while its 12-step column divider, row product
// and push are busy. Back alternates CALC and SEND per piece; the job queue
// lets the front decode the next descriptor while pieces drain.
// Reset (rst, synchronous) loads the register defaults and empties the queue.
// A stalled output holds its beat; the back waits and the queue fills behind it.
`timescale 1ns / 1ps
`default_nettype none
module transfer_block_splitter import tbs_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [5:0]            source_core,
  input  wire logic [5:0]            dst_core,
  input  wire logic [11:0]           src_col,
  input  wire logic [11:0]           dst_col,
  input  wire logic [12:0]           run_length,
  input  wire logic [9:0]            channel,
  input  wire logic [5:0]            batch,
  input  wire logic [7:0]            source_noc_x,
  input  wire logic [7:0]            source_noc_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [5:0]                 out_src_core,
  output logic [5:0]                 out_dst_core,
  output logic [5:0]                 block_index,
  output logic [27:0]                src_elem_offset,
  output logic [11:0]                block_col,
  output logic [12:0]                piece_length,
  output logic [7:0]                 out_noc_x,
  output logic [7:0]                 out_noc_y,
  output logic [30:0]                src_byte_offset,
  output logic [24:0]                dst_byte_offset,
  output logic [15:0]                piece_bytes,
  output logic                       last_piece
);
  cfg_t cfg;
  job_t push_job, pop_job;
  logic push, pop, q_full, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels    <= 11'd1;
      cfg.in_shard_w  <= 13'd1;
      cfg.elem_size   <= 4'd2;
      cfg.blk_width   <= 13'd32;
      cfg.out_shard_w <= 13'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNELS:    cfg.channels    <= cfg_data[10:0];
        CFG_IN_SHARD_W:  cfg.in_shard_w  <= cfg_data;
        CFG_ELEM_SIZE:   cfg.elem_size   <= cfg_data[3:0];
        CFG_BLK_WIDTH:   cfg.blk_width   <= cfg_data;
        CFG_OUT_SHARD_W: cfg.out_shard_w <= cfg_data;
        default: ;
      endcase
    end
  end

  tbs_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_stall,
    .source_core, .dst_core, .src_col, .dst_col, .run_length,
    .channel, .batch, .source_noc_x, .source_noc_y,
    .push, .job(push_job), .q_full
  );

  tbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .wr_data(push_job), .full(q_full),
    .pop, .valid(q_valid), .rd_data(pop_job)
  );

  tbs_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_data(pop_job), .pop,
    .out_valid, .out_stall, .out_src_core, .out_dst_core, .block_index,
    .src_elem_offset, .block_col, .piece_length, .out_noc_x, .out_noc_y,
    .src_byte_offset, .dst_byte_offset, .piece_bytes, .last_piece
  );
endmodule
`default_nettype wire

@@ sv/tbs_queue.sv @@
// tbs_queue: small register queue of decoded jobs between front and back.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbs_queue import tbs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      wr_data,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output job_t      rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/tbs_front.sv @@
// tbs_front: accepts descriptors, runs the column dividers and offset products,
// and pushes one decoded job per non-empty transfer. Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbs_front import tbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cfg_t             cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  source_core,
  input  wire logic [5:0]  dst_core,
  input  wire logic [11:0] src_col,
  input  wire logic [11:0] dst_col,
  input  wire logic [12:0] run_length,
  input  wire logic [9:0]  channel,
  input  wire logic [5:0]  batch,
  input  wire logic [7:0]  source_noc_x,
  input  wire logic [7:0]  source_noc_y,
  output logic             push,
  output job_t             job,
  input  wire logic        q_full
);
  front_state_t st, st_next;
  logic [3:0]  cnt;
  logic [5:0]  r_src_core, r_dst_core, r_batch;
  logic [7:0]  r_nx, r_ny;
  logic [11:0] r_src_col, r_dst_col, dvd, q1, q2;
  logic [12:0] r_len, r1, r2, bs_eff;
  logic [9:0]  r_channel;
  logic [16:0] prod1;
  logic [30:0] src_base;
  logic [24:0] row_bs;
  logic [13:0] t1, t2, end_excl, lim;
  logic        skip;

  assign bs_eff   = (cfg.blk_width == '0) ? 13'd1 : cfg.blk_width;
  assign t1       = {r1, dvd[11]};
  assign t2       = {r2, dvd[11]};
  assign end_excl = {2'b00, r_dst_col} + {1'b0, r_len};
  assign lim      = (end_excl < {1'b0, cfg.out_shard_w}) ? end_excl
                                                          : {1'b0, cfg.out_shard_w};
  assign skip     = ({2'b00, r_dst_col} >= lim);
  assign in_stall = (st != FR_IDLE);

  assign job.from_core = r_src_core;
  assign job.dst_core  = r_dst_core;
  assign job.noc_x     = r_nx;
  assign job.noc_y     = r_ny;
  assign job.src_base  = src_base;
  assign job.row_bs    = row_bs;
  assign job.start     = {2'b00, r_dst_col};
  assign job.lim       = lim;
  assign job.bstart    = {2'b00, r_dst_col - r2[11:0]};
  assign job.blk       = q2[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FR_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    push    = 1'b0;
    unique case (st)
      FR_IDLE: if (in_valid) st_next = FR_DIV;
      FR_DIV:  if (cnt == 4'(DIV_STEPS - 1)) st_next = FR_ROW;
      FR_ROW:  st_next = FR_PUSH;
      FR_PUSH: begin
        if (skip) begin
          st_next = FR_IDLE;
        end else if (!q_full) begin
          push    = 1'b1;
          st_next = FR_IDLE;
        end
      end
      default: st_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      FR_IDLE: begin
        r_src_core <= source_core;
        r_dst_core <= dst_core;
        r_src_col  <= src_col;
        r_dst_col  <= dst_col;
        r_len      <= run_length;
        r_channel  <= channel;
        r_batch    <= batch;
        r_nx       <= source_noc_x;
        r_ny       <= source_noc_y;
        dvd        <= dst_col;
        cnt        <= '0;
        r1         <= '0;
        r2         <= '0;
      end
      FR_DIV: begin
        cnt <= cnt + 1'b1;
        dvd <= {dvd[10:0], 1'b0};
        if (t1 >= {1'b0, cfg.out_shard_w}) begin
          r1 <= 13'(t1 - {1'b0, cfg.out_shard_w});
          q1 <= {q1[10:0], 1'b1};
        end else begin
          r1 <= t1[12:0];
          q1 <= {q1[10:0], 1'b0};
        end
        if (t2 >= {1'b0, bs_eff}) begin
          r2 <= 13'(t2 - {1'b0, bs_eff});
          q2 <= {q2[10:0], 1'b1};
        end else begin
          r2 <= t2[12:0];
          q2 <= {q2[10:0], 1'b0};
        end
        if (cnt == 4'd0) begin
          prod1 <= 17'(r_batch * cfg.channels) + {7'd0, r_channel};
        end
        if (cnt == 4'd1) begin
          src_base <= 31'(prod1 * cfg.in_shard_w) + {19'd0, r_src_col};
        end
      end
      FR_ROW: row_bs <= 25'(({3'b000, r_channel} + {1'b0, q1}) * bs_eff);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/tbs_back.sv @@
// tbs_back: walks the blocks of one job and emits one piece per beat.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbs_back import tbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  job_t      q_data,
  output logic      pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [5:0]  out_src_core,
  output logic [5:0]  out_dst_core,
  output logic [5:0]  block_index,
  output logic [27:0] src_elem_offset,
  output logic [11:0] block_col,
  output logic [12:0] piece_length,
  output logic [7:0]  out_noc_x,
  output logic [7:0]  out_noc_y,
  output logic [30:0] src_byte_offset,
  output logic [24:0] dst_byte_offset,
  output logic [15:0] piece_bytes,
  output logic        last_piece
);
  back_state_t st, st_next;
  job_t        job;
  logic [13:0] cur, p_oend;
  logic [14:0] bstart, bend;
  logic [5:0]  blk, n;
  logic [12:0] p_plen, p_local, bs_eff;
  logic [30:0] p_elem;
  logic [24:0] p_dsum;
  logic        p_last, load, oreg_free;
  logic [13:0] oend;

  assign bs_eff    = (cfg.blk_width == '0) ? 13'd1 : cfg.blk_width;
  assign bend      = bstart + {2'b00, bs_eff};
  assign oend      = (bend < {1'b0, job.lim}) ? bend[13:0] : job.lim;
  assign oreg_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    pop     = 1'b0;
    load    = 1'b0;
    unique case (st)
      BK_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          st_next = BK_CALC;
        end
      end
      BK_CALC: st_next = BK_SEND;
      BK_SEND: begin
        if (oreg_free) begin
          load    = 1'b1;
          st_next = p_last ? BK_IDLE : BK_CALC;
        end
      end
      default: st_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      BK_IDLE: begin
        job    <= q_data;
        cur    <= q_data.start;
        bstart <= {1'b0, q_data.bstart};
        blk    <= q_data.blk;
        n      <= '0;
      end
      BK_CALC: begin
        p_oend  <= oend;
        p_plen  <= 13'(oend - cur);
        p_local <= 13'(cur - bstart[13:0]);
        p_elem  <= job.src_base + {17'd0, cur - job.start};
        p_dsum  <= job.row_bs + 25'(cur - bstart[13:0]);
        p_last  <= (oend == job.lim) || (n == LAST_PIECE_NUM);
      end
      BK_SEND: begin
        if (load) begin
          cur    <= p_oend;
          bstart <= bend;
          blk    <= blk + 1'b1;
          n      <= n + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_src_core    <= job.from_core;
      out_dst_core    <= job.dst_core;
      block_index     <= blk;
      src_elem_offset <= p_elem[27:0];
      block_col       <= p_local[11:0];
      piece_length    <= p_plen;
      out_noc_x       <= job.noc_x;
      out_noc_y       <= job.noc_y;
      src_byte_offset <= 31'(p_elem * cfg.elem_size);
      dst_byte_offset <= 25'(p_dsum * cfg.elem_size);
      piece_bytes     <= 16'(p_plen * cfg.elem_size);
      last_piece      <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/tbs_checker.sv @@
// tbs_checker: port-level assertions for transfer_block_splitter, bound to the top.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tbs_checker import tbs_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_ready,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [27:0] src_elem_offset,
  input wire logic [12:0] piece_length,
  input wire logic        last_piece
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(src_elem_offset) && $stable(last_piece))
    else $error("stalled output beat changed");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_piece_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> piece_length != '0)
    else $error("empty piece emitted");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("front accepted without going busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind transfer_block_splitter tbs_checker u_tbs_checker (
  .clk, .rst, .cfg_ready, .in_valid, .in_stall, .out_valid, .out_stall,
  .src_elem_offset, .piece_length, .last_piece
);
`default_nettype wire
